// ----- sv/cagnms_pkg.sv -----
// Shared types and constants for the class-aware greedy NMS block.
// Depends on nothing; imported by cagnms_cell and class_aware_greedy_nms_top.
package cagnms_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned AREA_W  = 2 * COORD_W;
  localparam int unsigned THR_W   = 9;
  localparam int unsigned INDEX_W = 12;

  localparam logic [THR_W-1:0]   THR_RESET = 9'd115;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 12'hFFF;

  // One box as held in the kept store (56 bits)
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [LABEL_W-1:0] label;
  } box_t;

  // Item travelling down the cell chain
  typedef struct packed {
    logic              vld;
    logic              hit;
    box_t              box;
    logic [AREA_W-1:0] area;
  } token_t;

endpackage

// ----- sv/cagnms_cell.sv -----
// One cell of the suppression chain: holds one kept box and tests the passing item.
// Depends on cagnms_pkg (box_t, token_t, widths).
module cagnms_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cagnms_pkg::token_t          tok_i,
  output cagnms_pkg::token_t          tok_o,
  input  logic [cagnms_pkg::THR_W-1:0]  thr_i,
  input  logic                        active_i,
  input  logic                        wr_i,
  input  cagnms_pkg::box_t            wr_box_i,
  input  logic [cagnms_pkg::AREA_W-1:0] wr_area_i
);
  import cagnms_pkg::*;

  // Overlap of two 1-D extents, zero when disjoint
  function automatic logic [COORD_W-1:0] overlap(
    input logic [COORD_W-1:0] a0, input logic [COORD_W-1:0] alen,
    input logic [COORD_W-1:0] b0, input logic [COORD_W-1:0] blen
  );
    logic [COORD_W:0] a1;
    logic [COORD_W:0] b1;
    logic [COORD_W:0] lo;
    logic [COORD_W:0] hi;
    logic [COORD_W:0] diff;
    a1   = {1'b0, a0} + {1'b0, alen};
    b1   = {1'b0, b0} + {1'b0, blen};
    lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi   = (a1 < b1) ? a1 : b1;
    diff = (hi > lo) ? (hi - lo) : '0;
    return diff[COORD_W-1:0];
  endfunction

  box_t              kbox_q;
  logic [AREA_W-1:0] karea_q;

  token_t            tok1_q;
  logic [AREA_W-1:0] inter_q;
  logic              match_q;
  token_t            tok2_q;

  logic [COORD_W-1:0]  ov_x;
  logic [COORD_W-1:0]  ov_y;
  logic [AREA_W-1:0]   inter_d;
  logic [AREA_W:0]     uni;
  logic [AREA_W+7:0]   lhs;
  logic [AREA_W+THR_W:0] rhs;
  logic                exceeds;

  // Store the kept box when this slot is the next free one
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      kbox_q  <= wr_box_i;
      karea_q <= wr_area_i;
    end
  end

  // Stage one: intersection area and label match
  always_comb begin
    ov_x    = overlap(tok_i.box.x, tok_i.box.w, kbox_q.x, kbox_q.w);
    ov_y    = overlap(tok_i.box.y, tok_i.box.h, kbox_q.y, kbox_q.h);
    inter_d = {{COORD_W{1'b0}}, ov_x} * {{COORD_W{1'b0}}, ov_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q  <= '0;
      inter_q <= '0;
      match_q <= 1'b0;
    end else begin
      tok1_q  <= tok_i;
      inter_q <= inter_d;
      match_q <= active_i && (kbox_q.label == tok_i.box.label);
    end
  end

  // Stage two: inter*256 > threshold*union, no division
  always_comb begin
    uni     = {1'b0, tok1_q.area} + {1'b0, karea_q} - {1'b0, inter_q};
    lhs     = {inter_q, 8'b0};
    rhs     = {{(AREA_W+1){1'b0}}, thr_i} * {{THR_W{1'b0}}, uni};
    exceeds = {{(THR_W-7){1'b0}}, lhs} > rhs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
    end else begin
      tok2_q.vld  <= tok1_q.vld;
      tok2_q.hit  <= tok1_q.hit | (match_q & exceeds);
      tok2_q.box  <= tok1_q.box;
      tok2_q.area <= tok1_q.area;
    end
  end

  assign tok_o = tok2_q;

endmodule

// ----- sv/class_aware_greedy_nms_top.sv -----
// Top level of the class-aware greedy NMS block: control, cell chain, result register.
// Depends on cagnms_pkg and cagnms_cell.
//
// Usage:
//   Boxes of one frame arrive on the s_axis channel, sorted by descending
//   confidence; tlast marks the final box of the frame. Each box yields one
//   result item on m_axis: keep flag, index in the frame (saturating at 4095)
//   and store overflow, with tlast copying the frame end.
//   The box walks a chain of MAX_KEPT cells, two register stages per cell,
//   each cell holding one kept box. An item passes the load state, both
//   stages of every cell and the done state before its result is offered;
//   the next box is accepted only after that result enters the output
//   register, so a new box cannot enter the chain while another is in it.
//   The user must write the iou_threshold register through cfg_we_i/cfg_wdata_i
//   only while idle; the block does not enforce this. It resets to 115 (0.45 in Q1.8).
//   Reset empties the store, zeroes the frame index and drops any result.
//   When the receiver stalls, one result waits in the output register while a
//   further box may be accepted and processed; that box's result then holds
//   until the register frees.
module class_aware_greedy_nms_top #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // x[11:0], y[23:12], width[35:24], height[47:36], class_label[55:48]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // keep[0], box_index[12:1], store_overflow[13], zero[15:14]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  import cagnms_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);
  localparam logic [COORD_W-1:0] CMASK =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_KEPT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [THR_W-1:0]   thr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic               hit_q, hit_d;
  logic               m_valid_q, m_valid_d;
  logic [15:0]        m_data_q, m_data_d;
  logic               m_last_q, m_last_d;

  box_t               in_box_q;
  logic               in_last_q;
  logic [AREA_W-1:0]  in_area;

  token_t             chain [MAX_KEPT+1];

  logic               in_fire;
  logic               out_free;
  logic               fire_done;
  logic               keep;
  logic               room;
  logic               store_we;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fire_done     = (state_q == ST_DONE) && out_free;
  assign keep          = !hit_q;
  assign room          = (cnt_q < CNT_FULL);
  assign store_we      = fire_done && keep && room;

  // Capture the accepted box, coordinates cut to COORD_BITS
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_box_q.x     <= s_axis_tdata[11:0]  & CMASK;
      in_box_q.y     <= s_axis_tdata[23:12] & CMASK;
      in_box_q.w     <= s_axis_tdata[35:24] & CMASK;
      in_box_q.h     <= s_axis_tdata[47:36] & CMASK;
      in_box_q.label <= s_axis_tdata[55:48];
      in_last_q      <= s_axis_tlast;
    end
  end

  // Hold the overlap threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Inject the item into the head of the chain
  assign in_area = {{COORD_W{1'b0}}, in_box_q.w} * {{COORD_W{1'b0}}, in_box_q.h};

  always_comb begin
    chain[0].vld  = (state_q == ST_LOAD);
    chain[0].hit  = 1'b0;
    chain[0].box  = in_box_q;
    chain[0].area = in_area;
  end

  // Row of cells, one per store slot
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    cagnms_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1]),
      .thr_i     (thr_q),
      .active_i  (CNT_W'(i) < cnt_q),
      .wr_i      (store_we && (cnt_q == CNT_W'(i))),
      .wr_box_i  (in_box_q),
      .wr_area_i (in_area)
    );
  end

  // Next state, store count, index and result register
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (chain[MAX_KEPT].vld) begin
          hit_d   = chain[MAX_KEPT].hit;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, keep && !room, idx_q, keep};
          m_last_d  = in_last_q;
          if (store_we) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (idx_q != INDEX_MAX) begin
            idx_d = idx_q + INDEX_W'(1);
          end
          if (in_last_q) begin
            cnt_d = '0;
            idx_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // Store never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("kept count beyond store depth");

  // The item leaves the chain only while the controller waits for it
  a_chain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_KEPT].vld |-> (state_q == ST_RUN))
    else $error("item left the chain outside the run phase");

  // A finished item is offered in the next cycle
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_done |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("result not offered after completion");

  // Frame end empties the store and the index
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_done && in_last_q) |=> (cnt_q == '0) && (idx_q == '0))
    else $error("frame end did not clear the store");

endmodule
